FILE: hdl/assert_macros.svh
// Assertion macros used by the checker file of this block.
// Plain text macros only; no dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, masked while reset is asserted.
`define KSTM_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
        else $error("kstm check failed");

// Clocked check that also holds during reset.
`define KSTM_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) (prop)) \
        else $error("kstm reset check failed");

`endif

FILE: hdl/kstm_pkg.sv
// Shared types and constants of the key sequence table matcher.
// No dependencies.
package kstm_pkg;

    localparam int TABLE_ENTRIES_DEF   = 32;
    localparam int MAX_CODE_LENGTH_DEF = 16;
    localparam logic [15:0] TIMEOUT_RESET = 16'd5000;

    // Item kinds on s_tuser
    typedef enum logic [1:0] {
        OP_KEY  = 2'd0,
        OP_TICK = 2'd1,
        OP_LOAD = 2'd2
    } kstm_op_t;

    // Result kinds on m_tuser
    typedef enum logic [1:0] {
        OUT_ACCEPTED = 2'd0,
        OUT_MATCHED  = 2'd1,
        OUT_FAILED   = 2'd2,
        OUT_TIMEOUT  = 2'd3
    } kstm_outcome_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_EMIT
    } kstm_state_t;

endpackage

FILE: hdl/key_sequence_table_matcher.sv
// Key sequence table matcher: collects direction keys and matches them
// against a loadable code table. Depends on kstm_pkg and kstm_table.
//
// Each key press walks the whole table through one read port of the table
// memory, one entry per cycle, then stages its result for the output beat;
// ticks and table loads need no scan, and a tick that clears on timeout
// stages its result the same way before it is sent. The input is taken again
// as soon as the previous item has moved its result into the output stage,
// even if m_tready is low.
// Table entries read as unused after reset; no clearing pass is needed.
module key_sequence_table_matcher #(
    parameter int TABLE_ENTRIES   = kstm_pkg::TABLE_ENTRIES_DEF,
    parameter int MAX_CODE_LENGTH = kstm_pkg::MAX_CODE_LENGTH_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    // configuration: timeout_ticks
    input  logic        cfg_we,
    input  logic [15:0] cfg_wdata,
    // s_tuser: opcode[1:0]
    // s_tdata: direction[1:0], entry_index[6:2], entry_length[11:7],
    //          entry_directions[43:12], zero fill[47:44]
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [1:0]  s_tuser,
    input  logic [47:0] s_tdata,
    // m_tuser: outcome[1:0]
    // m_tdata: echo_direction[1:0], matched_index[6:2], typed_length[11:7],
    //          zero fill[15:12]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [1:0]  m_tuser,
    output logic [15:0] m_tdata
);

    localparam int IDX_W  = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int LEN_W  = $clog2(MAX_CODE_LENGTH + 1);
    localparam int CODE_W = 2 * MAX_CODE_LENGTH;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

    function automatic logic [CODE_W-1:0] code_mask(input logic [LEN_W-1:0] n);
        logic [CODE_W-1:0] m;
        m = '0;
        for (int p = 0; p < MAX_CODE_LENGTH; p++) begin
            if (LEN_W'(p) < n) begin
                m[2*p +: 2] = 2'b11;
            end
        end
        return m;
    endfunction

    // input fields
    kstm_pkg::kstm_op_t in_op;
    logic [1:0]         in_dir;
    logic [4:0]         in_index;
    logic [4:0]         in_length;
    logic [31:0]        in_codes;
    logic               in_beat;
    logic [CODE_W+31:0] codes_ext;

    // table port
    logic              wr_en;
    logic [IDX_W-1:0]  wr_addr;
    logic [LEN_W-1:0]  wr_len;
    logic [CODE_W-1:0] wr_codes;
    logic [IDX_W-1:0]  rd_addr;
    logic [LEN_W-1:0]  rd_len;
    logic [CODE_W-1:0] rd_codes;

    // state
    kstm_pkg::kstm_state_t state_reg, state_next;
    logic [15:0]       timeout_reg;
    logic [CODE_W-1:0] seq_reg, seq_next, seq_app;
    logic [LEN_W-1:0]  count_reg, count_next;
    logic [15:0]       remaining_reg, remaining_next;
    logic              running_reg, running_next;

    // scan
    logic [IDX_W-1:0] scan_idx_reg, scan_idx_next;
    logic             issue_done_reg, issue_done_next;
    logic             cmp_valid_reg, cmp_valid_next;
    logic [IDX_W-1:0] cmp_idx_reg, cmp_idx_next;
    logic             found_reg, found_next;
    logic [IDX_W-1:0] found_idx_reg, found_idx_next;
    logic             prefix_reg, prefix_next;
    logic             code_hit, exact_hit, prefix_hit;
    logic             found_now, prefix_now;
    logic [IDX_W-1:0] idx_now;

    // staged result and output stage
    kstm_pkg::kstm_outcome_t res_outcome_reg, res_outcome_next;
    logic [1:0]              res_dir_reg, res_dir_next;
    logic [4:0]              res_idx_reg, res_idx_next;
    logic [4:0]              res_len_reg, res_len_next;
    logic                    m_valid_reg, m_valid_next;
    kstm_pkg::kstm_outcome_t m_outcome_reg, m_outcome_next;
    logic [1:0]              m_dir_reg, m_dir_next;
    logic [4:0]              m_idx_reg, m_idx_next;
    logic [4:0]              m_len_reg, m_len_next;
    logic                    out_free;

    assign in_op     = kstm_pkg::kstm_op_t'(s_tuser);
    assign in_dir    = s_tdata[1:0];
    assign in_index  = s_tdata[6:2];
    assign in_length = s_tdata[11:7];
    assign in_codes  = s_tdata[43:12];
    assign codes_ext = (CODE_W + 32)'(in_codes);

    assign s_tready = (state_reg == kstm_pkg::ST_IDLE);
    assign in_beat  = s_tvalid && s_tready;
    assign out_free = !m_valid_reg || m_tready;

    assign wr_addr  = IDX_W'(in_index);
    assign wr_len   = (32'(in_length) > MAX_CODE_LENGTH) ? LEN_W'(MAX_CODE_LENGTH)
                                                         : LEN_W'(in_length);
    assign wr_codes = codes_ext[CODE_W-1:0] & code_mask(wr_len);
    assign rd_addr  = scan_idx_reg;

    kstm_table #(
        .ENTRIES (TABLE_ENTRIES),
        .IDX_W   (IDX_W),
        .LEN_W   (LEN_W),
        .CODE_W  (CODE_W)
    ) u_table (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_en    (wr_en),
        .wr_addr  (wr_addr),
        .wr_len   (wr_len),
        .wr_codes (wr_codes),
        .rd_addr  (rd_addr),
        .rd_len   (rd_len),
        .rd_codes (rd_codes)
    );

    always_comb begin
        seq_app = seq_reg;
        for (int p = 0; p < MAX_CODE_LENGTH; p++) begin
            if (LEN_W'(p) == count_reg) begin
                seq_app[2*p +: 2] = in_dir;
            end
        end
    end

    // compare of the entry read last cycle against the typed sequence
    assign code_hit   = (rd_codes & code_mask(count_reg)) == seq_reg;
    assign exact_hit  = code_hit && (rd_len == count_reg);
    assign prefix_hit = code_hit && (rd_len >= count_reg);
    assign found_now  = found_reg || exact_hit;
    assign idx_now    = found_reg ? found_idx_reg : cmp_idx_reg;
    assign prefix_now = prefix_reg || prefix_hit;

    always_comb begin
        state_next       = state_reg;
        seq_next         = seq_reg;
        count_next       = count_reg;
        remaining_next   = remaining_reg;
        running_next     = running_reg;
        scan_idx_next    = scan_idx_reg;
        issue_done_next  = issue_done_reg;
        cmp_valid_next   = 1'b0;
        cmp_idx_next     = cmp_idx_reg;
        found_next       = found_reg;
        found_idx_next   = found_idx_reg;
        prefix_next      = prefix_reg;
        res_outcome_next = res_outcome_reg;
        res_dir_next     = res_dir_reg;
        res_idx_next     = res_idx_reg;
        res_len_next     = res_len_reg;
        m_valid_next     = m_valid_reg && !m_tready;
        m_outcome_next   = m_outcome_reg;
        m_dir_next       = m_dir_reg;
        m_idx_next       = m_idx_reg;
        m_len_next       = m_len_reg;
        wr_en            = 1'b0;

        unique case (state_reg)
            kstm_pkg::ST_IDLE: begin
                if (in_beat) begin
                    unique case (in_op)
                        kstm_pkg::OP_LOAD: begin
                            wr_en = 32'(in_index) < TABLE_ENTRIES;
                        end
                        kstm_pkg::OP_TICK: begin
                            if (running_reg) begin
                                if (remaining_reg > 16'd1) begin
                                    remaining_next = remaining_reg - 16'd1;
                                end else begin
                                    remaining_next = '0;
                                    running_next   = 1'b0;
                                    if (count_reg != '0) begin
                                        res_outcome_next = kstm_pkg::OUT_TIMEOUT;
                                        res_dir_next     = '0;
                                        res_idx_next     = '0;
                                        res_len_next     = 5'(count_reg);
                                        seq_next         = '0;
                                        count_next       = '0;
                                        state_next       = kstm_pkg::ST_EMIT;
                                    end
                                end
                            end
                        end
                        kstm_pkg::OP_KEY: begin
                            seq_next        = seq_app;
                            count_next      = count_reg + 1'b1;
                            remaining_next  = timeout_reg;
                            running_next    = 1'b1;
                            res_dir_next    = in_dir;
                            scan_idx_next   = '0;
                            issue_done_next = 1'b0;
                            found_next      = 1'b0;
                            prefix_next     = 1'b0;
                            state_next      = kstm_pkg::ST_SCAN;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            kstm_pkg::ST_SCAN: begin
                if (!issue_done_reg) begin
                    cmp_valid_next = 1'b1;
                    cmp_idx_next   = scan_idx_reg;
                    if (scan_idx_reg == LAST_IDX) begin
                        issue_done_next = 1'b1;
                    end else begin
                        scan_idx_next = scan_idx_reg + 1'b1;
                    end
                end
                if (cmp_valid_reg) begin
                    // lowest index wins the exact match
                    if (exact_hit && !found_reg) begin
                        found_next     = 1'b1;
                        found_idx_next = cmp_idx_reg;
                    end
                    if (prefix_hit) begin
                        prefix_next = 1'b1;
                    end
                    if (cmp_idx_reg == LAST_IDX) begin
                        res_len_next = 5'(count_reg);
                        res_idx_next = '0;
                        state_next   = kstm_pkg::ST_EMIT;
                        if (found_now || !prefix_now) begin
                            res_outcome_next = found_now ? kstm_pkg::OUT_MATCHED
                                                         : kstm_pkg::OUT_FAILED;
                            if (found_now) begin
                                res_idx_next = 5'(idx_now);
                            end
                            seq_next       = '0;
                            count_next     = '0;
                            running_next   = 1'b0;
                            remaining_next = '0;
                        end else begin
                            res_outcome_next = kstm_pkg::OUT_ACCEPTED;
                        end
                    end
                end
            end
            kstm_pkg::ST_EMIT: begin
                if (out_free) begin
                    m_valid_next   = 1'b1;
                    m_outcome_next = res_outcome_reg;
                    m_dir_next     = res_dir_reg;
                    m_idx_next     = res_idx_reg;
                    m_len_next     = res_len_reg;
                    state_next     = kstm_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = kstm_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= kstm_pkg::ST_IDLE;
            timeout_reg   <= kstm_pkg::TIMEOUT_RESET;
            seq_reg       <= '0;
            count_reg     <= '0;
            remaining_reg <= '0;
            running_reg   <= 1'b0;
            cmp_valid_reg <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            if (cfg_we) begin
                timeout_reg <= cfg_wdata;
            end
            seq_reg       <= seq_next;
            count_reg     <= count_next;
            remaining_reg <= remaining_next;
            running_reg   <= running_next;
            cmp_valid_reg <= cmp_valid_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        scan_idx_reg    <= scan_idx_next;
        issue_done_reg  <= issue_done_next;
        cmp_idx_reg     <= cmp_idx_next;
        found_reg       <= found_next;
        found_idx_reg   <= found_idx_next;
        prefix_reg      <= prefix_next;
        res_outcome_reg <= res_outcome_next;
        res_dir_reg     <= res_dir_next;
        res_idx_reg     <= res_idx_next;
        res_len_reg     <= res_len_next;
        m_outcome_reg   <= m_outcome_next;
        m_dir_reg       <= m_dir_next;
        m_idx_reg       <= m_idx_next;
        m_len_reg       <= m_len_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_outcome_reg;
    assign m_tdata  = {4'b0000, m_len_reg, m_idx_reg, m_dir_reg};

endmodule

FILE: hdl/kstm_table.sv
// Code table storage: one synchronous memory of {length, codes} plus
// per-entry valid bits so unused entries read as length zero. Uses no package.
module kstm_table #(
    parameter int ENTRIES = 32,
    parameter int IDX_W   = 5,
    parameter int LEN_W   = 5,
    parameter int CODE_W  = 32
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              wr_en,
    input  logic [IDX_W-1:0]  wr_addr,
    input  logic [LEN_W-1:0]  wr_len,
    input  logic [CODE_W-1:0] wr_codes,
    input  logic [IDX_W-1:0]  rd_addr,
    output logic [LEN_W-1:0]  rd_len,
    output logic [CODE_W-1:0] rd_codes
);

    logic [LEN_W+CODE_W-1:0] mem [ENTRIES];
    logic [LEN_W+CODE_W-1:0] rd_data_reg;
    logic [ENTRIES-1:0]      valid_reg;
    logic                    rd_valid_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= {wr_len, wr_codes};
        end
        rd_data_reg <= mem[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end else begin
            if (wr_en) begin
                valid_reg[wr_addr] <= 1'b1;
            end
            rd_valid_reg <= valid_reg[rd_addr];
        end
    end

    assign rd_len   = rd_valid_reg ? rd_data_reg[LEN_W+CODE_W-1:CODE_W] : '0;
    assign rd_codes = rd_data_reg[CODE_W-1:0];

endmodule

FILE: hdl/kstm_checker.sv
// Port-level checks for key_sequence_table_matcher, bound to the top level.
// Depends on kstm_pkg and assert_macros.svh.
`include "assert_macros.svh"

module kstm_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [1:0]  m_tuser,
    input logic [15:0] m_tdata
);

    // a stalled result beat holds
    `KSTM_ASSERT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))

    // no result survives reset
    `KSTM_ASSERT_ALWAYS(a_reset_empty, aclk, !aresetn |=> !m_tvalid)

    // every result reports a non-empty sequence
    `KSTM_ASSERT(a_len_nonzero, aclk, aresetn, m_tvalid |-> m_tdata[11:7] != 5'd0)

    // index only carried by a match
    `KSTM_ASSERT(a_idx_match, aclk, aresetn, m_tvalid && m_tuser != kstm_pkg::OUT_MATCHED |-> m_tdata[6:2] == 5'd0)

    // timeout carries no direction
    `KSTM_ASSERT(a_tmo_dir, aclk, aresetn, m_tvalid && m_tuser == kstm_pkg::OUT_TIMEOUT |-> m_tdata[1:0] == 2'd0)

endmodule

bind key_sequence_table_matcher kstm_checker u_kstm_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tuser  (m_tuser),
    .m_tdata  (m_tdata)
);

FILE: test/key_sequence_table_matcher_tb.sv
// Testbench for key_sequence_table_matcher: random-gap stream driver, result monitor and
// an in-bench model of the key sequence matcher that predicts every result beat.
// Depends on kstm_pkg and the matcher RTL only.
module key_sequence_table_matcher_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int TBL_SIZE    = kstm_pkg::TABLE_ENTRIES_DEF;
    localparam int MAX_LEN     = kstm_pkg::MAX_CODE_LENGTH_DEF;
    localparam int CYCLE_LIMIT = 400000;
    localparam int SETTLE_CYC  = 50;
    localparam int HOLD_CYC    = 500;
    localparam logic [1:0] OP_UNUSED = 2'd3;

    typedef struct packed {
        logic [1:0]  op;
        logic [1:0]  dir;
        logic [4:0]  idx;
        logic [4:0]  len;
        logic [31:0] codes;
    } key_item_t;

    typedef struct packed {
        kstm_pkg::kstm_outcome_t outcome;
        logic [1:0]              dir;
        logic [4:0]              idx;
        logic [4:0]              len;
    } key_result_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_we = 1'b0;
    logic [15:0] cfg_wdata = '0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [1:0]  s_tuser = '0;
    logic [47:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [1:0]  m_tuser;
    logic [15:0] m_tdata;

    key_item_t   pend_q[$];
    key_result_t want_q[$];
    key_item_t   cur_item;
    int sent_cnt = 0;
    int taken_cnt = 0;
    int err_cnt = 0;
    int seen_cnt = 0;
    int cyc_cnt = 0;
    int tx_gap = 0;
    bit tx_calm = 1'b0;
    int rx_stall = 0;
    int hold_left = 0;
    bit hold_req = 1'b0;
    bit rx_calm = 1'b0;

    // matcher model state
    logic [15:0] tmo_cfg;
    logic [31:0] typed;
    int          typed_cnt;
    logic [15:0] tmr_left;
    bit          tmr_on;
    logic [31:0] tbl_codes[TBL_SIZE];
    int          tbl_len[TBL_SIZE];

    // what the stimulus side believes is loaded, to build matching key runs
    logic [31:0] plan_codes[TBL_SIZE];
    int          plan_len[TBL_SIZE];

    key_sequence_table_matcher dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tuser   (s_tuser),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tuser   (m_tuser),
        .m_tdata   (m_tdata)
    );

    always #1 aclk = ~aclk;

    function automatic logic [31:0] code_mask(input int n);
        if (n >= MAX_LEN) return '1;
        return (32'd1 << (2 * n)) - 32'd1;
    endfunction

    function automatic int draw_gap(input bit calm);
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 65) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic clear_typed();
        typed = '0;
        typed_cnt = 0;
        tmr_on = 1'b0;
        tmr_left = '0;
    endtask

    // Advance the matcher model by one accepted beat and queue its result, if it has one.
    task automatic match_step(input key_item_t it);
        logic [31:0] msk;
        logic [31:0] seq;
        int n;
        bit hit;
        bit pre;
        key_result_t r;
        r = '{kstm_pkg::OUT_ACCEPTED, it.dir, 5'd0, 5'd0};
        case (it.op)
            kstm_pkg::OP_LOAD: begin
                n = (it.len > MAX_LEN) ? MAX_LEN : it.len;
                tbl_len[it.idx] = n;
                tbl_codes[it.idx] = it.codes & code_mask(n);
            end
            kstm_pkg::OP_TICK: begin
                if (tmr_on) begin
                    if (tmr_left > 16'd1) begin
                        tmr_left = tmr_left - 16'd1;
                    end else begin
                        tmr_on = 1'b0;
                        tmr_left = '0;
                        if (typed_cnt != 0) begin
                            r = '{kstm_pkg::OUT_TIMEOUT, 2'd0, 5'd0, typed_cnt[4:0]};
                            want_q.push_back(r);
                            clear_typed();
                        end
                    end
                end
            end
            kstm_pkg::OP_KEY: begin
                typed = typed | (32'(it.dir) << (2 * typed_cnt));
                typed_cnt++;
                tmr_left = tmo_cfg;
                tmr_on = 1'b1;
                msk = code_mask(typed_cnt);
                seq = typed & msk;
                r.len = typed_cnt[4:0];
                hit = 1'b0;
                pre = 1'b0;
                for (int i = 0; i < TBL_SIZE; i++) begin
                    if (!hit && tbl_len[i] == typed_cnt && (tbl_codes[i] & msk) == seq) begin
                        hit = 1'b1;
                        r.idx = i[4:0];
                    end
                    // entries shorter than the typed run are skipped, not a stop
                    if (tbl_len[i] >= typed_cnt && (tbl_codes[i] & msk) == seq) pre = 1'b1;
                end
                if (hit) begin
                    r.outcome = kstm_pkg::OUT_MATCHED;
                    clear_typed();
                end else if (!pre) begin
                    r.outcome = kstm_pkg::OUT_FAILED;
                    clear_typed();
                end
                want_q.push_back(r);
            end
            default: ;
        endcase
    endtask

    // sender
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            tx_gap = 0;
            tmo_cfg = kstm_pkg::TIMEOUT_RESET;
            clear_typed();
            for (int i = 0; i < TBL_SIZE; i++) begin
                tbl_len[i] = 0;
                tbl_codes[i] = '0;
            end
        end else begin
            if (s_tvalid && s_tready) begin
                match_step(cur_item);
                taken_cnt++;
            end
            if (s_tvalid && !s_tready) begin
                // beat still offered, hold it
            end else if (tx_gap > 0) begin
                tx_gap--;
                s_tvalid <= 1'b0;
            end else if (pend_q.size() > 0) begin
                cur_item = pend_q.pop_front();
                s_tuser <= cur_item.op;
                s_tdata <= {4'b0, cur_item.codes, cur_item.len, cur_item.idx, cur_item.dir};
                s_tvalid <= 1'b1;
                tx_gap = draw_gap(tx_calm);
                if ($urandom_range(0, 39) == 0) tx_calm = !tx_calm;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // receiver ready, with one long hold-off on request
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (hold_req) begin
                hold_req = 1'b0;
                hold_left = HOLD_CYC;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else if (rx_stall > 0) begin
                rx_stall--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
                rx_stall = draw_gap(rx_calm);
                if ($urandom_range(0, 63) == 0) rx_calm = !rx_calm;
            end
        end
    end

    task automatic flag_error(input string msg);
        err_cnt++;
        if (err_cnt <= 10) $display("ERROR: %s", msg);
    endtask

    // monitor
    always @(posedge aclk) begin
        key_result_t w;
        if (aresetn && m_tvalid && m_tready) begin
            seen_cnt++;
            if (want_q.size() == 0) begin
                flag_error($sformatf("result beat %0d with nothing expected: tuser %0d tdata %h",
                                     seen_cnt, m_tuser, m_tdata));
            end else begin
                w = want_q.pop_front();
                if (m_tuser !== w.outcome || m_tdata[1:0] !== w.dir ||
                    m_tdata[6:2] !== w.idx || m_tdata[11:7] !== w.len ||
                    m_tdata[15:12] !== 4'b0) begin
                    flag_error($sformatf({"result beat %0d: expected outcome %0d dir %0d ",
                                          "index %0d length %0d, got %0d %0d %0d %0d fill %h"},
                                         seen_cnt, w.outcome, w.dir, w.idx, w.len, m_tuser,
                                         m_tdata[1:0], m_tdata[6:2], m_tdata[11:7],
                                         m_tdata[15:12]));
                end
            end
        end
    end

    always @(posedge aclk) begin
        cyc_cnt++;
        if (cyc_cnt > CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    task automatic push_item(input int op, input int dir, input int idx, input int len,
                             input logic [31:0] codes);
        key_item_t it;
        int n;
        it.op = op[1:0];
        it.dir = dir[1:0];
        it.idx = idx[4:0];
        it.len = len[4:0];
        it.codes = codes;
        if (it.op == kstm_pkg::OP_LOAD) begin
            n = (it.len > MAX_LEN) ? MAX_LEN : it.len;
            plan_len[it.idx] = n;
            plan_codes[it.idx] = codes & code_mask(n);
        end
        pend_q.push_back(it);
        sent_cnt++;
    endtask

    task automatic key(input int dir);
        push_item(kstm_pkg::OP_KEY, dir, $urandom, $urandom, $urandom);
    endtask

    task automatic tick();
        push_item(kstm_pkg::OP_TICK, $urandom, $urandom, $urandom, $urandom);
    endtask

    // wait until every beat is taken and every result is back, then let the block drain
    task automatic settle();
        while (taken_cnt != sent_cnt || want_q.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYC) @(posedge aclk);
    endtask

    task automatic set_timeout(input logic [15:0] v);
        settle();
        @(posedge aclk);
        cfg_we <= 1'b1;
        cfg_wdata <= v;
        @(posedge aclk);
        cfg_we <= 1'b0;
        tmo_cfg = v;
    endtask

    // Mostly key runs that follow a loaded entry, plus loads, stray keys, ticks, noise.
    task automatic add_random(input int count);
        int made;
        int pick;
        int n;
        int r;
        int tries;
        int d;
        made = 0;
        while (made < count) begin
            r = $urandom_range(0, 99);
            if (r < 10) begin
                d = $urandom_range(0, 99);
                n = (d < 50) ? $urandom_range(1, 4) : (d < 75) ? $urandom_range(5, MAX_LEN) :
                    (d < 88) ? $urandom_range(MAX_LEN + 1, 31) : 0;
                push_item(kstm_pkg::OP_LOAD, $urandom, $urandom, n, $urandom);
                made++;
            end else if (r < 60) begin
                pick = $urandom_range(0, TBL_SIZE - 1);
                tries = 0;
                while (plan_len[pick] == 0 && tries < TBL_SIZE) begin
                    pick = (pick + 1) % TBL_SIZE;
                    tries++;
                end
                n = (plan_len[pick] == 0) ? 1 : plan_len[pick];
                if ($urandom_range(0, 3) == 0) n = $urandom_range(1, n);
                for (int k = 0; k < n; k++) begin
                    d = plan_codes[pick][2*k +: 2];
                    if (k == n - 1 && $urandom_range(0, 4) == 0) d = $urandom_range(0, 3);
                    key(d);
                    made++;
                    if ($urandom_range(0, 9) == 0) begin
                        tick();
                        made++;
                    end
                end
            end else if (r < 80) begin
                key($urandom_range(0, 3));
                made++;
            end else if (r < 97) begin
                n = (tmo_cfg <= 16'd8) ? $urandom_range(1, tmo_cfg + 1) : $urandom_range(1, 3);
                repeat (n) tick();
                made += n;
            end else begin
                push_item(OP_UNUSED, $urandom, $urandom, $urandom, $urandom);
                made++;
            end
        end
    endtask

    initial begin
        for (int i = 0; i < TBL_SIZE; i++) begin
            plan_len[i] = 0;
            plan_codes[i] = '0;
        end
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        // directed, reset timeout
        key(0);                                                // empty table: fail
        push_item(kstm_pkg::OP_LOAD, 0, 0, 0, 32'h0);          // unused entry
        push_item(kstm_pkg::OP_LOAD, 0, 0, 3, 32'hFFFF_FF24);  // U D L, junk above
        push_item(kstm_pkg::OP_LOAD, 0, 9, 3, 32'h24);         // same code, higher index
        push_item(kstm_pkg::OP_LOAD, 0, 31, 31, 32'hFFFF_FFFF); // overlong, saturates
        push_item(kstm_pkg::OP_LOAD, 0, 6, 1, 32'h1);          // D
        push_item(kstm_pkg::OP_LOAD, 0, 7, 4, 32'h4E);         // L R U D
        push_item(OP_UNUSED, 3, 31, 31, 32'hFFFF_FFFF);
        key(0);
        key(1);
        tick();
        key(2);                                 // lowest exact index wins
        key(2);
        key(3);                                 // shorter entry 6 skipped
        key(0);
        key(1);
        key(3);
        key(2);                                 // R L starts nothing
        push_item(kstm_pkg::OP_LOAD, 0, 31, 0, 32'h0);
        key(3);

        // zero timeout acts as one tick
        set_timeout(16'd0);
        key(0);
        tick();
        tick();                                 // timer already stopped
        key(0);
        key(1);
        tick();

        set_timeout(16'hFFFF);
        add_random(100);

        set_timeout(16'($urandom_range(2, 6)));
        add_random(250);
        hold_req = 1'b1;

        set_timeout(16'd1);
        add_random(100);

        settle();
        if (err_cnt == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
